// File: hw/rtl/rmst_pkg.sv
// rmst_pkg: shared types, sizes, codes and the pair compare for the range-min segment tree
// no dependencies; imported by range_min_segment_tree_core
`default_nettype none

package rmst_pkg;

	localparam int LEAVES = 1024;
	localparam int LEAF_W = $clog2(LEAVES);
	localparam int NODES  = 2 * LEAVES;
	localparam int NODE_W = LEAF_W + 1;
	localparam int QIDX_W = NODE_W + 1;

	localparam int VAL_W  = 32;
	localparam int TAG_W  = 16;
	localparam int MODE_W = 3;
	localparam int END_W  = LEAF_W + 1;

	localparam logic signed [VAL_W-1:0] ID_VAL_RST = 32'sd1000000000;
	localparam logic [TAG_W-1:0]        ID_TAG_RST = '0;

	localparam logic [MODE_W-1:0] MODE_SET   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_BUILD = 3'd1;
	localparam logic [MODE_W-1:0] MODE_UPD   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_QUERY = 3'd3;
	localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd5;

	localparam logic CFG_ID_VAL = 1'b0;
	localparam logic CFG_ID_TAG = 1'b1;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [VAL_W-1:0] val;
	} node_t;

	localparam int NODE_BITS = $bits(node_t);

	// lexicographic minimum: value first (signed), then tag
	function automatic node_t pair_min(input node_t a, input node_t b);
		logic b_lt;
		if (a.val != b.val)
			b_lt = $signed(b.val) < $signed(a.val);
		else
			b_lt = b.tag < a.tag;
		return b_lt ? b : a;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rmst_ram.sv
// rmst_ram: generic single-write, single-read RAM with registered read data
// no dependencies; used for the node store of range_min_segment_tree_core
`default_nettype none

module rmst_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 2048,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: hw/rtl/range_min_segment_tree_core.sv
// range_min_segment_tree_core: bottom-up min segment tree with a sequencer around one node RAM
// depends on rmst_pkg and rmst_ram
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata: position, range_end, key_value, key_tag; s_tuser: mode
//  m_*      out  m_tvalid/m_tready  m_tdata: min_value, min_tag; m_tuser: is_answer
//  cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data (identity value / tag)
//
// each request runs as a sequence of states, set by the single RAM read port and the shared pair compare:
//  set and read touch one leaf, update rewrites the leaf and walks its ancestors up to the root,
//  query walks both bounds up the tree, build fills nodes LEAVES-1 down to 1, clear fills every node
// after reset a clearing pass fills the RAM; s_tready stays low meanwhile
// s_tready is high only when the sequencer is idle; one result may wait in the output register
`default_nettype none

module range_min_segment_tree_core
	import rmst_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,   // position, range_end, key_value, key_tag, zero pad
	input  wire logic [2:0]  s_tuser,   // mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // min_value, min_tag
	output logic             m_tuser,   // is_answer
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SET  = 4'd1;
	localparam logic [3:0] S_UPDL = 4'd2;
	localparam logic [3:0] S_UPDR = 4'd3;
	localparam logic [3:0] S_UPDW = 4'd4;
	localparam logic [3:0] S_BLDL = 4'd5;
	localparam logic [3:0] S_BLDR = 4'd6;
	localparam logic [3:0] S_BLDW = 4'd7;
	localparam logic [3:0] S_QA   = 4'd8;
	localparam logic [3:0] S_QB   = 4'd9;
	localparam logic [3:0] S_RD   = 4'd10;
	localparam logic [3:0] S_RD2  = 4'd11;
	localparam logic [3:0] S_CLR  = 4'd12;
	localparam logic [3:0] S_FIN  = 4'd13;

	logic [3:0]        st_q;
	logic [LEAF_W-1:0] pos_q;
	node_t             key_q;
	node_t             acc_q;
	node_t             res_q;
	logic              ans_q;
	logic              pend_q;
	logic              clr_ack_q;
	logic [NODE_W-1:0] c_q;
	logic [LEAF_W-1:0] k_q;
	logic [QIDX_W-1:0] a_q;
	logic [QIDX_W-1:0] b_q;
	logic [NODE_W-1:0] cnt_q;
	node_t             fill_q;
	logic [VAL_W-1:0]  idv_q;
	logic [TAG_W-1:0]  idt_q;
	logic              m_tvalid_q;
	logic [47:0]       m_tdata_q;
	logic              m_tuser_q;

	logic [MODE_W-1:0] in_mode;
	logic [LEAF_W-1:0] in_pos;
	logic [END_W-1:0]  in_end;
	node_t             in_key;
	logic [END_W-1:0]  end_c;
	logic [END_W-1:0]  pos_c;
	node_t             ident;

	logic                 we;
	logic [NODE_W-1:0]    waddr;
	node_t                wdata;
	logic [NODE_W-1:0]    raddr;
	logic [NODE_BITS-1:0] rdata_raw;
	node_t                rd;
	node_t                min_out;
	node_t                acc_nxt;
	logic                 s_acc;
	logic                 out_free;

	assign in_mode    = s_tuser;
	assign in_pos     = s_tdata[9:0];
	assign in_end     = s_tdata[20:10];
	assign in_key.val = s_tdata[52:21];
	assign in_key.tag = s_tdata[68:53];

	// query bounds clamp
	assign end_c = (in_end > END_W'(LEAVES)) ? END_W'(LEAVES) : in_end;
	assign pos_c = ({1'b0, in_pos} > end_c) ? end_c : {1'b0, in_pos};

	assign ident.val = idv_q;
	assign ident.tag = idt_q;

	assign rd      = node_t'(rdata_raw);
	assign min_out = pair_min(acc_q, rd);
	assign acc_nxt = pend_q ? min_out : acc_q;

	assign s_tready  = (st_q == S_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	rmst_ram #(
		.WIDTH(NODE_BITS),
		.DEPTH(NODES)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata_raw)
	);

	// node RAM port selection
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = key_q;
		raddr = '0;
		case (st_q)
			S_SET, S_UPDL: begin
				we    = 1'b1;
				waddr = {1'b1, pos_q};
			end
			S_UPDR: raddr = {c_q[NODE_W-1:1], ~c_q[0]};
			S_UPDW: begin
				we    = 1'b1;
				waddr = {1'b0, c_q[NODE_W-1:1]};
				wdata = min_out;
			end
			S_BLDL: raddr = {k_q, 1'b0};
			S_BLDR: raddr = {k_q, 1'b1};
			S_BLDW: begin
				we    = 1'b1;
				waddr = {1'b0, k_q};
				wdata = min_out;
			end
			S_QA: raddr = a_q[NODE_W-1:0];
			S_QB: raddr = {b_q[NODE_W-1:1], 1'b0};
			S_RD: raddr = {1'b1, pos_q};
			S_CLR: begin
				we    = 1'b1;
				waddr = cnt_q;
				wdata = fill_q;
			end
			default: ;
		endcase
	end

	// identity registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idv_q <= ID_VAL_RST;
			idt_q <= ID_TAG_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ID_VAL: idv_q <= cfg_data;
				CFG_ID_TAG: idt_q <= cfg_data[TAG_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_CLR;
			cnt_q      <= '0;
			fill_q.val <= ID_VAL_RST;
			fill_q.tag <= ID_TAG_RST;
			clr_ack_q  <= 1'b0;
			pend_q     <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (s_acc) begin
						pos_q  <= in_pos;
						key_q  <= in_key;
						res_q  <= '0;
						ans_q  <= 1'b0;
						pend_q <= 1'b0;
						case (in_mode)
							MODE_SET: st_q <= S_SET;
							MODE_BUILD: begin
								k_q  <= LEAF_W'(LEAVES - 1);
								st_q <= S_BLDL;
							end
							MODE_UPD: st_q <= S_UPDL;
							MODE_QUERY: begin
								a_q   <= QIDX_W'(LEAVES) + QIDX_W'(pos_c);
								b_q   <= QIDX_W'(LEAVES) + QIDX_W'(end_c);
								acc_q <= ident;
								st_q  <= S_QA;
							end
							MODE_READ: st_q <= S_RD;
							MODE_CLEAR: begin
								cnt_q     <= '0;
								fill_q    <= ident;
								clr_ack_q <= 1'b1;
								st_q      <= S_CLR;
							end
							default: st_q <= S_FIN;
						endcase
					end
				end
				S_SET: st_q <= S_FIN;
				S_UPDL: begin
					acc_q <= key_q;
					c_q   <= {1'b1, pos_q};
					st_q  <= S_UPDR;
				end
				S_UPDR: st_q <= S_UPDW;
				S_UPDW: begin
					acc_q <= min_out;
					c_q   <= c_q >> 1;
					if (c_q[NODE_W-1:1] == (NODE_W-1)'(1))
						st_q <= S_FIN;
					else
						st_q <= S_UPDR;
				end
				S_BLDL: st_q <= S_BLDR;
				S_BLDR: begin
					acc_q <= rd;
					st_q  <= S_BLDW;
				end
				S_BLDW: begin
					if (k_q == LEAF_W'(1)) begin
						st_q <= S_FIN;
					end else begin
						k_q  <= k_q - LEAF_W'(1);
						st_q <= S_BLDL;
					end
				end
				S_QA: begin
					acc_q <= acc_nxt;
					if (a_q < b_q) begin
						pend_q <= a_q[0];
						if (a_q[0])
							a_q <= a_q + QIDX_W'(1);
						st_q <= S_QB;
					end else begin
						pend_q <= 1'b0;
						res_q  <= acc_nxt;
						ans_q  <= 1'b1;
						st_q   <= S_FIN;
					end
				end
				S_QB: begin
					acc_q  <= acc_nxt;
					pend_q <= b_q[0];
					a_q    <= a_q >> 1;
					b_q    <= b_q >> 1;
					st_q   <= S_QA;
				end
				S_RD: st_q <= S_RD2;
				S_RD2: begin
					res_q <= rd;
					ans_q <= 1'b1;
					st_q  <= S_FIN;
				end
				S_CLR: begin
					cnt_q <= cnt_q + NODE_W'(1);
					if (cnt_q == NODE_W'(NODES - 1)) begin
						clr_ack_q <= 1'b0;
						st_q      <= clr_ack_q ? S_FIN : S_IDLE;
					end
				end
				S_FIN: begin
					if (out_free) begin
						m_tdata_q <= res_q;
						m_tuser_q <= ans_q;
						st_q      <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if ((st_q == S_FIN) && out_free)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

`ifndef SYNTHESIS
	// a result only appears after the finish state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(st_q == S_FIN))
		else $error("result raised outside finish state");

	// query walk keeps its bounds ordered and inside the tree
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_QB) |-> (a_q <= b_q) && (b_q <= QIDX_W'(NODES)))
		else $error("query bounds out of order");

	// update walk never reaches the root's parent
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_UPDW) |-> (c_q[NODE_W-1:1] != '0))
		else $error("update walked past the root");

	// an accepted request always leaves idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (st_q != S_IDLE))
		else $error("request accepted but sequencer stayed idle");
`endif

endmodule

`default_nettype wire

// File: tb/tb_range_min_segment_tree_core.sv
// tb_range_min_segment_tree_core: self-checking bench for the range-min segment tree core
// keeps a shadow tree, predicts every result and compares it field by field on the m_* stream
// depends on rmst_pkg and range_min_segment_tree_core
`timescale 1ns / 1ps
`default_nettype none

module tb_range_min_segment_tree_core
	import rmst_pkg::*;
();

	localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int PHASE_ITEMS = 165;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [LEAF_W-1:0] position;
		logic [END_W-1:0]  range_end;
		logic [VAL_W-1:0]  key_value;
		logic [TAG_W-1:0]  key_tag;
	} request_t;

	typedef struct packed {
		logic [VAL_W-1:0] val;
		logic [TAG_W-1:0] tag;
		logic             is_answer;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_ID_VAL;
	logic [31:0] cfg_data = '0;

	node_t       shadow_tree [NODES];
	node_t       neutral_pair;
	request_t    pending_ops[$];
	answer_t     expected_minima[$];
	request_t    bus_op;
	request_t    next_op;
	int          send_gap = 0;
	int          recv_stall = 0;
	bit          calm = 1'b0;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;

	range_min_segment_tree_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// order key: flipped sign bit makes the signed value compare as unsigned, tag breaks ties
	function automatic logic [VAL_W+TAG_W-1:0] order_key(input node_t n);
		return {~n.val[VAL_W-1], n.val[VAL_W-2:0], n.tag};
	endfunction

	function automatic node_t lesser(input node_t a, input node_t b);
		return (order_key(b) < order_key(a)) ? b : a;
	endfunction

	function automatic answer_t tree_step(input request_t r);
		answer_t res;
		node_t   lo;
		node_t   hi;
		node_t   key;
		int      a;
		int      b;
		int      k;
		int      stop;
		res = '0;
		key.val = r.key_value;
		key.tag = r.key_tag;
		case (r.mode)
			MODE_SET: shadow_tree[LEAVES + r.position] = key;
			MODE_BUILD: begin
				for (k = LEAVES - 1; k > 0; k--)
					shadow_tree[k] = lesser(shadow_tree[2*k], shadow_tree[2*k+1]);
			end
			MODE_UPD: begin
				k = LEAVES + r.position;
				shadow_tree[k] = key;
				for (k = k >> 1; k > 0; k = k >> 1)
					shadow_tree[k] = lesser(shadow_tree[2*k], shadow_tree[2*k+1]);
			end
			MODE_QUERY: begin
				stop = (r.range_end > LEAVES) ? LEAVES : int'(r.range_end);
				a = r.position;
				if (a > stop)
					a = stop;
				a += LEAVES;
				b = stop + LEAVES;
				lo = neutral_pair;
				hi = neutral_pair;
				while (a < b) begin
					if (a[0]) begin
						lo = lesser(lo, shadow_tree[a]);
						a++;
					end
					if (b[0]) begin
						b--;
						hi = lesser(shadow_tree[b], hi);
					end
					a = a >> 1;
					b = b >> 1;
				end
				lo = lesser(lo, hi);
				res.val = lo.val;
				res.tag = lo.tag;
				res.is_answer = 1'b1;
			end
			MODE_READ: begin
				res.val = shadow_tree[LEAVES + r.position].val;
				res.tag = shadow_tree[LEAVES + r.position].tag;
				res.is_answer = 1'b1;
			end
			MODE_CLEAR: begin
				foreach (shadow_tree[i])
					shadow_tree[i] = neutral_pair;
			end
			default: ;
		endcase
		return res;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_minima.insert(expected_minima.size(), tree_step(bus_op));
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					next_op = pending_ops.pop_front();
					bus_op <= next_op;
					s_tdata <= {3'b000, next_op.key_tag, next_op.key_value,
						next_op.range_end, next_op.position};
					s_tuser <= next_op.mode;
					s_tvalid <= 1'b1;
					if (!calm && $urandom_range(0, 9) == 0)
						send_gap <= $urandom_range(1, 18);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_minima.size() == 0) begin
					$error("result with nothing expected: min_value %0d min_tag %0d is_answer %0b",
						$signed(m_tdata[31:0]), m_tdata[47:32], m_tuser);
					fail_count++;
				end else begin
					want = expected_minima.pop_front();
					if (m_tdata[31:0] !== want.val) begin
						$error("min_value: expected %0d, got %0d",
							$signed(want.val), $signed(m_tdata[31:0]));
						fail_count++;
					end
					if (m_tdata[47:32] !== want.tag) begin
						$error("min_tag: expected %0d, got %0d", want.tag, m_tdata[47:32]);
						fail_count++;
					end
					if (m_tuser !== want.is_answer) begin
						$error("is_answer: expected %0b, got %0b", want.is_answer, m_tuser);
						fail_count++;
					end
				end
			end
			if (recv_stall > 0) begin
				recv_stall <= recv_stall - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!calm && $urandom_range(0, 9) == 0)
					recv_stall <= $urandom_range(1, 18);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic queue_op(input logic [MODE_W-1:0] m, input int p, input int e,
			input logic [VAL_W-1:0] v, input logic [TAG_W-1:0] t);
		request_t r;
		r.mode = m;
		r.position = p[LEAF_W-1:0];
		r.range_end = e[END_W-1:0];
		r.key_value = v;
		r.key_tag = t;
		pending_ops.insert(pending_ops.size(), r);
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2, 3: return $urandom_range(0, 8) - 4;
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_leaf();
		return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 1023);
	endfunction

	task automatic queue_random_op();
		logic [MODE_W-1:0] m;
		int                w;
		int                p;
		int                e;
		logic [TAG_W-1:0]  t;
		w = $urandom_range(0, 99);
		if (w < 8)
			m = MODE_SET;
		else if (w < 11)
			m = MODE_BUILD;
		else if (w < 46)
			m = MODE_UPD;
		else if (w < 78)
			m = MODE_QUERY;
		else if (w < 93)
			m = MODE_READ;
		else if (w < 94)
			m = MODE_CLEAR;
		else if (w < 97)
			m = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
		else
			m = MODE_QUERY;
		p = pick_leaf();
		e = $urandom_range(0, 2047);
		if (m == MODE_QUERY) begin
			if ($urandom_range(0, 1) == 0) begin
				p = $urandom_range(0, 63);
				e = $urandom_range(0, 80);
			end else if ($urandom_range(0, 99) < 85) begin
				e = $urandom_range(p, 1024);
			end
		end
		t = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
		queue_op(m, p, e, pick_value(), t);
	endtask

	task automatic write_identity(input logic idx, input logic [31:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_ID_VAL)
			neutral_pair.val = data;
		else
			neutral_pair.tag = data[TAG_W-1:0];
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending_ops.size() != 0 || s_tvalid || expected_minima.size() != 0);
		repeat (10) @(posedge clk);
	endtask

	initial begin
		logic [VAL_W-1:0] id_vals [5];
		logic [TAG_W-1:0] id_tags [5];
		neutral_pair.val = ID_VAL_RST;
		neutral_pair.tag = ID_TAG_RST;
		foreach (shadow_tree[i])
			shadow_tree[i] = neutral_pair;
		id_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'($urandom), ID_VAL_RST};
		id_tags = '{16'hFFFF, 16'h0, 16'($urandom), 16'($urandom), ID_TAG_RST};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// clearing pass after reset
		do @(posedge clk); while (!s_tready);

		queue_op(MODE_READ, 0, 0, 0, 0);
		queue_op(MODE_QUERY, 0, 1024, 0, 0);
		queue_op(MODE_SET, 0, 0, 32'h8000_0000, 16'hFFFF);
		// stale ancestors until a build
		queue_op(MODE_QUERY, 0, 1024, 0, 0);
		queue_op(MODE_READ, 0, 0, 0, 0);
		queue_op(MODE_BUILD, 0, 0, 0, 0);
		queue_op(MODE_QUERY, 0, 1024, 0, 0);
		queue_op(MODE_UPD, 1023, 0, 32'h7FFF_FFFF, 16'h0);
		queue_op(MODE_UPD, 5, 0, 32'h8000_0000, 16'h0003);
		// range end clamped, equal values decided by tag
		queue_op(MODE_QUERY, 0, 2047, 0, 0);
		queue_op(MODE_QUERY, 5, 5, 0, 0);
		queue_op(MODE_QUERY, 9, 3, 0, 0);
		queue_op(MODE_QUERY, 1023, 1024, 0, 0);
		queue_op(MODE_QUERY, 1000, 1500, 0, 0);
		queue_op(MODE_QUERY, 6, 1023, 0, 0);
		queue_op(MODE_READ, 1023, 0, 0, 0);
		queue_op(MODE_SPARE_A, 1023, 2047, 32'hFFFF_FFFF, 16'hFFFF);
		queue_op(MODE_SPARE_B, 1023, 2047, 32'hFFFF_FFFF, 16'hFFFF);
		queue_op(MODE_CLEAR, 0, 0, 0, 0);
		queue_op(MODE_READ, 5, 0, 0, 0);
		queue_op(MODE_QUERY, 0, 1024, 0, 0);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			write_identity(CFG_ID_VAL, id_vals[ph]);
			write_identity(CFG_ID_TAG, {16'h0, id_tags[ph]});
			if (ph == 4)
				calm = 1'b1;
			repeat (PHASE_ITEMS) queue_random_op();
			drain();
		end

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
